>>> rtl/core/trp_pkg.sv
// trp_pkg: shared types and constants for the telemetry record packer
// holds the record tables and the frame job type passed front to back
// no dependencies
package trp_pkg;

    localparam int NUM_REC     = 9;
    localparam int REC_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    // byte position inside a record
    localparam logic [1:0] POS_CHANNEL = 2'd0;
    localparam logic [1:0] POS_TYPE    = 2'd1;
    localparam logic [1:0] POS_VAL_HI  = 2'd2;
    localparam logic [1:0] POS_VAL_LO  = 2'd3;

    // record sizes in bytes
    localparam logic [2:0] CHARGE_REC_BYTES = 3'd3;
    localparam logic [2:0] WORD_REC_BYTES   = 3'd4;

    localparam logic [7:0] REC_CHANNEL [NUM_REC] = '{
        8'd23, 8'd1, 8'd3, 8'd21, 8'd2, 8'd4, 8'd5, 8'd22, 8'd24
    };
    localparam logic [7:0] REC_TYPE [NUM_REC] = '{
        8'd184, 8'd190, 8'd103, 8'd186, 8'd191, 8'd112, 8'd115, 8'd185, 8'd103
    };

    typedef struct packed {
        logic [NUM_REC-1:0][15:0] vals;     // entry 0 holds charge in its low byte
        logic [NUM_REC-1:0]       keep;     // records written to the frame
        logic [3:0]               dropped;
        logic [6:0]               length;
    } t_job;

endpackage

>>> rtl/core/trp_front.sv
// trp_front: classifies one request into the records that fit the budget
// depends on trp_pkg
module trp_front #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic          i_valid,
    input  logic          i_queue_full,
    input  logic [7:0]    i_battery_charge,
    input  logic [15:0]   i_wind_rate,
    input  logic [15:0]   i_air_temperature,
    input  logic [15:0]   i_battery_voltage,
    input  logic [15:0]   i_wind_heading,
    input  logic [15:0]   i_humidity,
    input  logic [15:0]   i_pressure,
    input  logic [15:0]   i_battery_current,
    input  logic [15:0]   i_battery_temperature,
    input  logic [8:0]    i_present_mask,
    input  logic [7:0]    i_byte_budget,
    output logic          o_ready,
    output logic          o_push,
    output trp_pkg::t_job o_job
);
    import trp_pkg::*;

    localparam logic [7:0] MAX_BUDGET = 8'(MAX_FRAME_BYTES);

    logic [7:0]         budget;
    logic               charge_fit;
    logic [7:0]         room;
    logic [5:0]         word_room;
    logic [3:0]         word_seen;
    logic [3:0]         words_kept;
    logic [3:0]         dropped;
    logic [5:0]         len;
    logic [NUM_REC-1:0] keep;

    assign budget = (i_byte_budget == 8'd0 || i_byte_budget > MAX_BUDGET)
                    ? MAX_BUDGET : i_byte_budget;

    // charge goes first; what is left is shared by the four-byte word records
    assign charge_fit = i_present_mask[0] && (budget >= 8'(CHARGE_REC_BYTES));
    assign room       = charge_fit ? (budget - 8'(CHARGE_REC_BYTES)) : budget;
    assign word_room  = room[7:2];

    // word records are all the same size: once one misses, every later one
    // misses too, so the kept ones are the first word_room present ones
    always_comb begin
        word_seen = 4'd0;
        keep      = '0;
        keep[0]   = charge_fit;
        for (int i = 1; i < NUM_REC; i++) begin
            if (i_present_mask[i]) begin
                word_seen = word_seen + 4'd1;
                if ({2'b00, word_seen} <= word_room) begin
                    keep[i] = 1'b1;
                end
            end
        end
    end

    assign words_kept = ({2'b00, word_seen} > word_room) ? word_room[3:0] : word_seen;
    assign dropped    = 4'(i_present_mask[0] && !charge_fit) + (word_seen - words_kept);
    assign len        = (charge_fit ? 6'(CHARGE_REC_BYTES) : 6'd0) + {words_kept, 2'b00};

    always_comb begin
        o_job.vals[0] = {8'd0, i_battery_charge};
        o_job.vals[1] = i_wind_rate;
        o_job.vals[2] = i_air_temperature;
        o_job.vals[3] = i_battery_voltage;
        o_job.vals[4] = i_wind_heading;
        o_job.vals[5] = i_humidity;
        o_job.vals[6] = i_pressure;
        o_job.vals[7] = i_battery_current;
        o_job.vals[8] = i_battery_temperature;
        o_job.keep    = keep;
        o_job.dropped = dropped;
        o_job.length  = {1'b0, len};
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule

>>> rtl/core/trp_queue.sv
// trp_queue: short job queue between front and back
// depends on trp_pkg
module trp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trp_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output trp_pkg::t_job o_job
);
    import trp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> rtl/core/trp_back.sv
// trp_back: walks the kept records of the head job, one frame byte a cycle unless the output stalls
// depends on trp_pkg
module trp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  trp_pkg::t_job i_head,
    output logic          o_pop,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_frame_byte,
    output logic          o_frame_empty,
    output logic          o_frame_last,
    output logic [3:0]    o_records_dropped,
    output logic [6:0]    o_frame_length
);
    import trp_pkg::*;

    logic [NUM_REC-1:0] r_done;
    logic [1:0]         r_pos;
    logic               r_out_valid;
    logic [7:0]         r_byte;
    logic               r_empty;
    logic               r_last;
    logic [3:0]         r_dropped;
    logic [6:0]         r_length;

    logic [NUM_REC-1:0]   rem;
    logic [NUM_REC-1:0]   cur_oh;
    logic [REC_IDX_W-1:0] cur_idx;
    logic [7:0]           cur_chan;
    logic [7:0]           cur_type;
    logic [15:0]          cur_val;
    logic                 is_empty;
    logic                 rec_end;
    logic                 frame_end;
    logic                 emit;
    logic [7:0]           n_byte;

    assign rem    = i_head.keep & ~r_done;
    assign cur_oh = rem & (~rem + 1'b1);

    always_comb begin
        cur_idx  = '0;
        cur_chan = 8'd0;
        cur_type = 8'd0;
        for (int i = 0; i < NUM_REC; i++) begin
            if (cur_oh[i]) begin
                cur_idx  = REC_IDX_W'(i);
                cur_chan = cur_chan | REC_CHANNEL[i];
                cur_type = cur_type | REC_TYPE[i];
            end
        end
    end

    assign cur_val   = i_head.vals[cur_idx];
    assign is_empty  = (i_head.keep == '0);
    assign rec_end   = cur_oh[0] ? (r_pos == POS_VAL_HI) : (r_pos == POS_VAL_LO);
    assign frame_end = is_empty || (rec_end && ((rem & ~cur_oh) == '0));
    assign emit      = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_pop     = emit && frame_end;

    always_comb begin
        n_byte = 8'd0;
        if (!is_empty) begin
            unique case (r_pos)
                POS_CHANNEL: n_byte = cur_chan;
                POS_TYPE:    n_byte = cur_type;
                POS_VAL_HI:  n_byte = cur_oh[0] ? cur_val[7:0] : cur_val[15:8];
                POS_VAL_LO:  n_byte = cur_val[7:0];
                default:     n_byte = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_pos       <= POS_CHANNEL;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (frame_end) begin
                    r_done <= '0;
                    r_pos  <= POS_CHANNEL;
                end else if (rec_end) begin
                    r_done <= r_done | cur_oh;
                    r_pos  <= POS_CHANNEL;
                end else begin
                    r_pos <= r_pos + 2'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte    <= n_byte;
            r_empty   <= is_empty;
            r_last    <= frame_end;
            r_dropped <= i_head.dropped;
            r_length  <= i_head.length;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_byte      = r_byte;
    assign o_frame_empty     = r_empty;
    assign o_frame_last      = r_last;
    assign o_records_dropped = r_dropped;
    assign o_frame_length    = r_length;

endmodule

>>> rtl/core/telemetry_record_packer.sv
// telemetry_record_packer: an accepted request passes the job queue and the output register before its first frame byte
// throughput: one frame byte per cycle while the output is not stalled, set by the single byte-wide
// output register; a request yields max(1, frame_length) output items, at most 35
// a two-entry job queue lets the input side take requests while a frame drains
// reset (synchronous, active low) empties the queue and clears the output valid
// depends on trp_pkg, trp_front, trp_queue, trp_back
module telemetry_record_packer #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_battery_charge,
    input  logic [15:0] i_wind_rate,
    input  logic [15:0] i_air_temperature,
    input  logic [15:0] i_battery_voltage,
    input  logic [15:0] i_wind_heading,
    input  logic [15:0] i_humidity,
    input  logic [15:0] i_pressure,
    input  logic [15:0] i_battery_current,
    input  logic [15:0] i_battery_temperature,
    input  logic [8:0]  i_present_mask,
    input  logic [7:0]  i_byte_budget,
    // frame byte side
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_empty,
    output logic        o_frame_last,
    output logic [3:0]  o_records_dropped,
    output logic [6:0]  o_frame_length
);
    import trp_pkg::*;

    // front to queue
    logic queue_full;
    logic push;
    t_job front_job;
    // queue to back
    logic head_valid;
    t_job head_job;
    logic pop;

    // front: clamp the budget and pick the records that fit, all in the accept cycle
    trp_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_valid              (i_in_valid),
        .i_queue_full         (queue_full),
        .i_battery_charge     (i_battery_charge),
        .i_wind_rate          (i_wind_rate),
        .i_air_temperature    (i_air_temperature),
        .i_battery_voltage    (i_battery_voltage),
        .i_wind_heading       (i_wind_heading),
        .i_humidity           (i_humidity),
        .i_pressure           (i_pressure),
        .i_battery_current    (i_battery_current),
        .i_battery_temperature(i_battery_temperature),
        .i_present_mask       (i_present_mask),
        .i_byte_budget        (i_byte_budget),
        .o_ready              (o_in_ready),
        .o_push               (push),
        .o_job                (front_job)
    );

    // classified jobs wait here so the front need not wait on a draining frame unless the queue is full
    trp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .i_pop  (pop),
        .o_full (queue_full),
        .o_valid(head_valid),
        .o_job  (head_job)
    );

    // back: serializes the head job; pops it on its last byte so the next
    // frame follows with no gap
    trp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head_job),
        .o_pop            (pop),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_frame_byte     (o_frame_byte),
        .o_frame_empty    (o_frame_empty),
        .o_frame_last     (o_frame_last),
        .o_records_dropped(o_records_dropped),
        .o_frame_length   (o_frame_length)
    );

endmodule

>>> rtl/core/trp_checker.sv
// trp_checker: port-level checks on the packer output stream, bound to the top level
// no dependencies
module trp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_empty,
    input logic       o_frame_last,
    input logic [3:0] o_records_dropped,
    input logic [6:0] o_frame_length
);

    // stalled output holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_frame_byte) && $stable(o_frame_last))
        else $error("output changed while stalled");

    // empty marker is a one-item frame of length zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_empty |-> o_frame_last && o_frame_length == 7'd0)
        else $error("bad empty marker");

    // a real frame has a length of one to 35 bytes and at most nine dropped records
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_empty |->
            o_frame_length != 7'd0 && o_frame_length <= 7'd35 &&
            o_records_dropped <= 4'd9)
        else $error("frame length out of range");

    // inside a frame bytes follow with no gap and frame totals stay put
    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_frame_last |=>
            o_out_valid && !o_frame_empty && $stable(o_frame_length) &&
            $stable(o_records_dropped))
        else $error("frame broken mid-stream");

endmodule

bind telemetry_record_packer trp_checker u_trp_checker (.*);

>>> test/telemetry_record_packer_test.sv
`timescale 1ns / 100ps
// telemetry_record_packer_test: self-checking bench for the telemetry record packer
// predicts each packed frame from the request fields and checks every frame byte
// depends on telemetry_record_packer and trp_pkg (through the block only)
module telemetry_record_packer_test;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_REQUESTS = 400;
    localparam int STEADY_REQUESTS = 60;
    localparam int NUM_READINGS    = 9;

    // reading index, also the bit of the present mask and the priority order
    localparam int R_CHARGE       = 0;
    localparam int R_WIND_RATE    = 1;
    localparam int R_AIR_TEMP     = 2;
    localparam int R_BATT_VOLT    = 3;
    localparam int R_WIND_HEADING = 4;
    localparam int R_HUMIDITY     = 5;
    localparam int R_PRESSURE     = 6;
    localparam int R_BATT_CURRENT = 7;
    localparam int R_BATT_TEMP    = 8;

    // record channel codes
    localparam logic [7:0] CH_WIND_RATE    = 8'd1;
    localparam logic [7:0] CH_WIND_HEADING = 8'd2;
    localparam logic [7:0] CH_AIR_TEMP     = 8'd3;
    localparam logic [7:0] CH_HUMIDITY     = 8'd4;
    localparam logic [7:0] CH_PRESSURE     = 8'd5;
    localparam logic [7:0] CH_BATT_VOLT    = 8'd21;
    localparam logic [7:0] CH_BATT_CURRENT = 8'd22;
    localparam logic [7:0] CH_CHARGE       = 8'd23;
    localparam logic [7:0] CH_BATT_TEMP    = 8'd24;

    // record type codes
    localparam logic [7:0] TY_TEMPERATURE  = 8'd103;
    localparam logic [7:0] TY_HUMIDITY     = 8'd112;
    localparam logic [7:0] TY_PRESSURE     = 8'd115;
    localparam logic [7:0] TY_CHARGE       = 8'd184;
    localparam logic [7:0] TY_CURRENT      = 8'd185;
    localparam logic [7:0] TY_VOLTAGE      = 8'd186;
    localparam logic [7:0] TY_WIND_RATE    = 8'd190;
    localparam logic [7:0] TY_WIND_HEADING = 8'd191;

    localparam int CHARGE_BYTES = 3;
    localparam int WORD_BYTES   = 4;

    // one request: the nine readings, the present mask and the byte budget
    typedef struct packed {
        logic [7:0]  charge;
        logic [15:0] wind_rate;
        logic [15:0] air_temp;
        logic [15:0] batt_volt;
        logic [15:0] wind_heading;
        logic [15:0] humidity;
        logic [15:0] pressure;
        logic [15:0] batt_current;
        logic [15:0] batt_temp;
        logic [8:0]  mask;
        logic [7:0]  budget;
    } t_sample;

    // one frame byte as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       empty;
        logic       last;
        logic [3:0] dropped;
        logic [6:0] length;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_battery_charge = '0;
    logic [15:0] i_wind_rate = '0;
    logic [15:0] i_air_temperature = '0;
    logic [15:0] i_battery_voltage = '0;
    logic [15:0] i_wind_heading = '0;
    logic [15:0] i_humidity = '0;
    logic [15:0] i_pressure = '0;
    logic [15:0] i_battery_current = '0;
    logic [15:0] i_battery_temperature = '0;
    logic [8:0]  i_present_mask = '0;
    logic [7:0]  i_byte_budget = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_frame_byte;
    logic        o_frame_empty;
    logic        o_frame_last;
    logic [3:0]  o_records_dropped;
    logic [6:0]  o_frame_length;

    t_frame_byte frame_bytes_due[$];
    int          failures = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;   // long receiver hold-off, counted down by the receiver
    bit          steady = 1'b0;     // no idling on either side once set

    telemetry_record_packer #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_battery_charge     (i_battery_charge),
        .i_wind_rate          (i_wind_rate),
        .i_air_temperature    (i_air_temperature),
        .i_battery_voltage    (i_battery_voltage),
        .i_wind_heading       (i_wind_heading),
        .i_humidity           (i_humidity),
        .i_pressure           (i_pressure),
        .i_battery_current    (i_battery_current),
        .i_battery_temperature(i_battery_temperature),
        .i_present_mask       (i_present_mask),
        .i_byte_budget        (i_byte_budget),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_frame_byte         (o_frame_byte),
        .o_frame_empty        (o_frame_empty),
        .o_frame_last         (o_frame_last),
        .o_records_dropped    (o_records_dropped),
        .o_frame_length       (o_frame_length)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // frame prediction
    // ---------------------------------------------------------------

    // channel and type bytes of each record
    function automatic logic [15:0] record_header(input int idx);
        case (idx)
            R_CHARGE:       record_header = {CH_CHARGE,       TY_CHARGE};
            R_WIND_RATE:    record_header = {CH_WIND_RATE,    TY_WIND_RATE};
            R_AIR_TEMP:     record_header = {CH_AIR_TEMP,     TY_TEMPERATURE};
            R_BATT_VOLT:    record_header = {CH_BATT_VOLT,    TY_VOLTAGE};
            R_WIND_HEADING: record_header = {CH_WIND_HEADING, TY_WIND_HEADING};
            R_HUMIDITY:     record_header = {CH_HUMIDITY,     TY_HUMIDITY};
            R_PRESSURE:     record_header = {CH_PRESSURE,     TY_PRESSURE};
            R_BATT_CURRENT: record_header = {CH_BATT_CURRENT, TY_CURRENT};
            default:        record_header = {CH_BATT_TEMP,    TY_TEMPERATURE};
        endcase
    endfunction

    // raw reading bits; signed readings already travel as two's complement
    function automatic logic [15:0] reading_word(input t_sample s, input int idx);
        case (idx)
            R_CHARGE:       reading_word = {8'd0, s.charge};
            R_WIND_RATE:    reading_word = s.wind_rate;
            R_AIR_TEMP:     reading_word = s.air_temp;
            R_BATT_VOLT:    reading_word = s.batt_volt;
            R_WIND_HEADING: reading_word = s.wind_heading;
            R_HUMIDITY:     reading_word = s.humidity;
            R_PRESSURE:     reading_word = s.pressure;
            R_BATT_CURRENT: reading_word = s.batt_current;
            default:        reading_word = s.batt_temp;
        endcase
    endfunction

    // builds the expected frame of one request and queues its bytes
    function automatic void pack_frame(input t_sample s);
        logic [7:0]  frame[$];
        logic [15:0] hdr;
        logic [15:0] word;
        t_frame_byte fb;
        int          limit;
        int          rec_bytes;
        int          dropped;
        int          idx;
        int          n;
        limit = s.budget;
        // zero or oversized budget falls back to the full frame
        if (limit == 0 || limit > MAX_FRAME_BYTES) begin
            limit = MAX_FRAME_BYTES;
        end
        dropped = 0;
        for (idx = 0; idx < NUM_READINGS; idx++) begin
            rec_bytes = (idx == R_CHARGE) ? CHARGE_BYTES : WORD_BYTES;
            if (s.mask[idx]) begin
                // a record that does not fit whole is skipped, later ones may still fit
                if (frame.size() + rec_bytes > limit) begin
                    dropped++;
                end else begin
                    hdr  = record_header(idx);
                    word = reading_word(s, idx);
                    frame.push_back(hdr[15:8]);
                    frame.push_back(hdr[7:0]);
                    if (idx == R_CHARGE) begin
                        frame.push_back(word[7:0]);
                    end else begin
                        frame.push_back(word[15:8]);
                        frame.push_back(word[7:0]);
                    end
                end
            end
        end
        if (frame.size() == 0) begin
            // nothing written: a single marker item
            fb.data    = 8'd0;
            fb.empty   = 1'b1;
            fb.last    = 1'b1;
            fb.dropped = 4'(dropped);
            fb.length  = 7'd0;
            frame_bytes_due.push_back(fb);
        end else begin
            for (n = 0; n < frame.size(); n++) begin
                fb.data    = frame[n];
                fb.empty   = 1'b0;
                fb.last    = (n == frame.size() - 1);
                fb.dropped = 4'(dropped);
                fb.length  = 7'(frame.size());
                frame_bytes_due.push_back(fb);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // frame byte checker
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            failures++;
            $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_bytes_due.size() == 0) begin
                failures++;
                $display("%0t: frame byte expected none actual %0d", $time, o_frame_byte);
            end else begin
                want = frame_bytes_due.pop_front();
                check_field("frame_byte", want.data, o_frame_byte);
                check_field("frame_empty", want.empty, o_frame_empty);
                check_field("frame_last", want.last, o_frame_last);
                check_field("records_dropped", want.dropped, o_records_dropped);
                check_field("frame_length", want.length, o_frame_length);
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall bursts, one long hold-off on request
    // ---------------------------------------------------------------

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (!steady && stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                // now and then arm a burst of stalled cycles
                if (!steady && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    // watchdog on total run length
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("telemetry_record_packer: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // offers one request and holds it until accepted, then predicts its frame
    task automatic send_request(input t_sample s);
        @(negedge i_clk);
        i_in_valid            <= 1'b1;
        i_battery_charge      <= s.charge;
        i_wind_rate           <= s.wind_rate;
        i_air_temperature     <= s.air_temp;
        i_battery_voltage     <= s.batt_volt;
        i_wind_heading        <= s.wind_heading;
        i_humidity            <= s.humidity;
        i_pressure            <= s.pressure;
        i_battery_current     <= s.batt_current;
        i_battery_temperature <= s.batt_temp;
        i_present_mask        <= s.mask;
        i_byte_budget         <= s.budget;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pack_frame(s);
    endtask

    // drops valid for a burst of cycles
    task automatic idle_for(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!steady && $urandom_range(0, 3) == 0) begin
            idle_for($urandom_range(1, 8));
        end
    endtask

    // sender pause until every predicted byte has been seen
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample();
        t_sample s;
        s.charge       = 8'($urandom);
        s.wind_rate    = 16'($urandom);
        s.air_temp     = 16'($urandom);
        s.batt_volt    = 16'($urandom);
        s.wind_heading = 16'($urandom);
        s.humidity     = 16'($urandom);
        s.pressure     = 16'($urandom);
        s.batt_current = 16'($urandom);
        s.batt_temp    = 16'($urandom);
        s.mask         = ($urandom_range(0, 3) == 0) ? 9'h1FF : 9'($urandom_range(0, 511));
        case ($urandom_range(0, 9))
            0, 1:    s.budget = 8'd0;
            2:       s.budget = 8'($urandom_range(MAX_FRAME_BYTES + 1, 255));
            3:       s.budget = 8'($urandom_range(0, 3));
            4:       s.budget = 8'(MAX_FRAME_BYTES);
            default: s.budget = 8'($urandom_range(3, 40));
        endcase
        return s;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // frames with no record: nothing present, or budget below every record
    task automatic test_empty_frames();
        t_sample s;
        s = random_sample();
        s.mask = 9'h000;
        send_request(s);
        s = random_sample();
        s.mask   = 9'h1FF;
        s.budget = 8'd1;
        send_request(s);
        s = random_sample();
        s.mask   = 9'h1FF;
        s.budget = 8'd2;
        send_request(s);
    endtask

    // field extremes and budget clamping
    task automatic test_field_extremes();
        t_sample s;
        s = '0;
        s.mask = 9'h1FF;
        send_request(s);                    // all zero, budget zero means full frame
        s = '1;
        send_request(s);                    // all ones, budget above the maximum
        s = random_sample();
        s.air_temp     = 16'h8000;
        s.batt_current = 16'h7FFF;
        s.batt_temp    = 16'h8000;
        s.mask         = 9'h1FF;
        s.budget       = 8'(MAX_FRAME_BYTES);
        send_request(s);
        s = random_sample();
        s.air_temp     = 16'h7FFF;
        s.batt_current = 16'h8000;
        s.batt_temp    = 16'hFFFF;
        s.mask         = 9'h1FF;
        s.budget       = 8'(MAX_FRAME_BYTES + 1);
        send_request(s);
    endtask

    // each record on its own
    task automatic test_single_records();
        t_sample s;
        int      idx;
        for (idx = 0; idx < NUM_READINGS; idx++) begin
            s = random_sample();
            s.mask   = 9'(1 << idx);
            s.budget = 8'd0;
            send_request(s);
            maybe_idle();
        end
    endtask

    // budgets right at record boundaries: skipped records counted as dropped
    task automatic test_partial_fit();
        t_sample s;
        s = random_sample();
        s.mask   = 9'h1FF;
        s.budget = 8'd3;                    // charge only
        send_request(s);
        s = random_sample();
        s.mask   = 9'h1FE;
        s.budget = 8'd4;                    // first word record only
        send_request(s);
        s = random_sample();
        s.mask   = 9'h1FF;
        s.budget = 8'd6;                    // charge fits, no word record after it
        send_request(s);
        s = random_sample();
        s.mask   = 9'h1FF;
        s.budget = 8'd35;                   // exactly the full frame
        send_request(s);
        s = random_sample();
        s.mask   = 9'h1FF;
        s.budget = 8'd34;                   // last record just misses
        send_request(s);
        s = random_sample();
        s.mask   = 9'h155;
        s.budget = 8'd10;
        send_request(s);
    endtask

    // receiver holds off long while the sender keeps offering full frames
    task automatic test_backpressure();
        t_sample s;
        @(negedge i_clk);
        hold_cycles = 200;
        repeat (8) begin
            s = random_sample();
            s.mask   = 9'h1FF;
            s.budget = 8'd0;
            send_request(s);
        end
    endtask

    // random requests; the last stretch runs with no idling at all
    task automatic test_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if (k == count - STEADY_REQUESTS) begin
                steady = 1'b1;
            end
            send_request(random_sample());
            maybe_idle();
        end
    endtask

    initial begin
        // hold the synchronous reset, then release it
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_frames();
        test_field_extremes();
        wait_drained();
        test_single_records();
        test_partial_fit();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_random(RANDOM_REQUESTS);
        wait_drained();

        // let the clock run on to catch any stray frame byte
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("telemetry_record_packer: match");
        end else begin
            $display("telemetry_record_packer: mismatch");
        end
        $finish;
    end

endmodule
